// File: rtl/assert_macros.svh
// Assertion macros for the cosine nearest vector select RTL.
// Each macro expands to one labelled concurrent assertion reporting by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CNVS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cnvs assertion failed");

// Next-cycle implication, disabled during reset.
`define CNVS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cnvs assertion failed");

`endif

// File: rtl/cnvs_pkg.sv
// Shared types and constants for the cosine nearest vector select block.
// No dependencies.
`default_nettype none

package cnvs_pkg;

   // Default bound on compared candidates per set.
   localparam int MAX_CANDIDATES_DEFAULT = 256;

   // Largest positive Q1.15 similarity.
   localparam logic [15:0] SIM_MAX = 16'h7FFF;

   // One 3-D Q8.8 vector.
   typedef struct packed {
      logic signed [15:0] north;
      logic signed [15:0] east;
      logic signed [15:0] down;
   } vec_type;

   // One classified beat travelling from the front end to the back end.
   typedef struct packed {
      vec_type     cand;
      vec_type     refv;
      logic [7:0]  pos;
      logic        start;
      logic        cmp;
      logic        last;
   } entry_type;

   // Back-end sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PROD = 7'b0000010,
      ST_NORM = 7'b0000100,
      ST_SQRT = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_UPDT = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/cosine_nearest_vector_select_core.sv
// Cosine nearest vector select: top level joining front end, queue and back end.
// Depends on cnvs_pkg, cnvs_front, cnvs_queue and cnvs_back.
//
// Usage: candidate beats arrive on the req_ valid/ready channel, each with a
// reference vector (taken when req_first is high) and a candidate vector.
// The block computes the cosine similarity of every candidate against the held
// reference in Q1.15 and keeps the best; on a beat with req_last high one result
// beat (winning vector, index in the set, similarity) leaves on the rsp_ channel.
// The back end works on one candidate at a time. A compared candidate passes
// through the pop, three component products, one length product, 32 square
// root steps, 16 divide steps and one update; a zero-length candidate skips the
// square root and divider, and an ignored one goes from the pop to the update.
// The last beat of a set adds the emit state. The iterative square root and
// divider take most of the time; queue wait adds to the delay of a result.
// A two-entry queue lets the input take beats while the back end works.
// Reset clears the held reference, the running best and the set counter.
// While the receiver stalls, the result holds in its output register and the
// back end waits before its next result; input beats are still queued.
`default_nettype none

module cosine_nearest_vector_select_core #(
   parameter int MAX_CANDIDATES = cnvs_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_ref_north,
   input  wire logic signed [15:0] req_ref_east,
   input  wire logic signed [15:0] req_ref_down,
   input  wire logic signed [15:0] req_cand_north,
   input  wire logic signed [15:0] req_cand_east,
   input  wire logic signed [15:0] req_cand_down,
   input  wire logic               req_first,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_best_north,
   output logic signed [15:0]      rsp_best_east,
   output logic signed [15:0]      rsp_best_down,
   output logic [7:0]              rsp_best_index,
   output logic signed [15:0]      rsp_best_similarity
);

   logic                q_full, q_push, q_pop, q_valid;
   cnvs_pkg::entry_type q_wdata, q_rdata;

   cnvs_front #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ref_north  (req_ref_north),
      .req_ref_east   (req_ref_east),
      .req_ref_down   (req_ref_down),
      .req_cand_north (req_cand_north),
      .req_cand_east  (req_cand_east),
      .req_cand_down  (req_cand_down),
      .req_first      (req_first),
      .req_last       (req_last),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wdata)
   );

   cnvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   cnvs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_data              (q_rdata),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_north      (rsp_best_north),
      .rsp_best_east       (rsp_best_east),
      .rsp_best_down       (rsp_best_down),
      .rsp_best_index      (rsp_best_index),
      .rsp_best_similarity (rsp_best_similarity)
   );

endmodule

`default_nettype wire

// File: rtl/cnvs_front.sv
// Front end: accepts input beats, latches the reference and classifies each
// candidate within its set. Depends on cnvs_pkg.
`default_nettype none

module cnvs_front #(
   parameter int MAX_CANDIDATES = cnvs_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_ref_north,
   input  wire logic signed [15:0] req_ref_east,
   input  wire logic signed [15:0] req_ref_down,
   input  wire logic signed [15:0] req_cand_north,
   input  wire logic signed [15:0] req_cand_east,
   input  wire logic signed [15:0] req_cand_down,
   input  wire logic               req_first,
   input  wire logic               req_last,
   input  wire logic               q_full,
   output logic                    q_push,
   output cnvs_pkg::entry_type     q_data
);

   localparam int CW = $clog2(MAX_CANDIDATES + 1);

   cnvs_pkg::vec_type refv_ff, refv_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     eff;
   logic              cmp;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Position of this beat within its set; a missing first restarts at zero.
   always_comb begin
      eff     = req_first ? '0 : cnt_ff;
      cmp     = eff < CW'(MAX_CANDIDATES);
      refv_in = refv_ff;
      cnt_in  = cnt_ff;
      if (q_push) begin
         if (req_first) begin
            refv_in.north = req_ref_north;
            refv_in.east  = req_ref_east;
            refv_in.down  = req_ref_down;
         end
         if (req_last) begin
            cnt_in = '0;
         end else if (cmp) begin
            cnt_in = eff + CW'(1);
         end else begin
            cnt_in = eff;
         end
      end
   end

   // Classified beat for the queue.
   always_comb begin
      q_data.cand.north = req_cand_north;
      q_data.cand.east  = req_cand_east;
      q_data.cand.down  = req_cand_down;
      q_data.refv       = req_first ? {req_ref_north, req_ref_east, req_ref_down} : refv_ff;
      q_data.pos        = 8'(eff);
      q_data.start      = (eff == '0);
      q_data.cmp        = cmp;
      q_data.last       = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refv_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         refv_ff <= refv_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cnvs_queue.sv
// Two-entry queue decoupling the front end from the back end.
// Depends on cnvs_pkg.
`default_nettype none

module cnvs_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cnvs_pkg::entry_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output cnvs_pkg::entry_type       pop_data
);

   cnvs_pkg::entry_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cnvs_back.sv
// Back end: sequential similarity unit (products, square root, division),
// running best tracking and the result register. Depends on cnvs_pkg and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cnvs_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire cnvs_pkg::entry_type  q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [15:0]        rsp_best_north,
   output logic signed [15:0]        rsp_best_east,
   output logic signed [15:0]        rsp_best_down,
   output logic [7:0]                rsp_best_index,
   output logic signed [15:0]        rsp_best_similarity
);

   cnvs_pkg::state_type state_ff, state_in;
   cnvs_pkg::entry_type item_ff, item_in;
   logic [4:0]          step_ff, step_in;
   logic signed [32:0]  dot_ff, dot_in;
   logic [31:0]         na_ff, na_in;
   logic [31:0]         nb_ff, nb_in;
   logic [63:0]         srem_ff, srem_in;
   logic [63:0]         root_ff, root_in;
   logic [63:0]         bit_ff, bit_in;
   logic [31:0]         den_ff, den_in;
   logic [32:0]         drem_ff, drem_in;
   logic [15:0]         quo_ff, quo_in;
   logic signed [15:0]  sim_ff, sim_in;
   cnvs_pkg::vec_type   best_ff, best_in;
   logic signed [15:0]  bsim_ff, bsim_in;
   logic [7:0]          bpos_ff, bpos_in;
   logic                ovalid_ff, ovalid_in;
   cnvs_pkg::vec_type   ovec_ff, ovec_in;
   logic [7:0]          opos_ff, opos_in;
   logic signed [15:0]  osim_ff, osim_in;

   logic signed [15:0]  ra, ca;
   logic signed [31:0]  p_rc, p_rr, p_cc;
   logic [63:0]         ssum;
   logic [32:0]         absdot;
   logic [33:0]         trial;
   logic                ge;
   logic                out_free;

   assign out_free = !ovalid_ff || rsp_ready;
   assign q_pop    = (state_ff == cnvs_pkg::ST_IDLE) && q_valid;

   assign rsp_valid           = ovalid_ff;
   assign rsp_best_north      = ovec_ff.north;
   assign rsp_best_east       = ovec_ff.east;
   assign rsp_best_down       = ovec_ff.down;
   assign rsp_best_index      = opos_ff;
   assign rsp_best_similarity = osim_ff;

   // Component selection and the three per-component products.
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            ra = item_ff.refv.north;
            ca = item_ff.cand.north;
         end
         2'd1: begin
            ra = item_ff.refv.east;
            ca = item_ff.cand.east;
         end
         default: begin
            ra = item_ff.refv.down;
            ca = item_ff.cand.down;
         end
      endcase
      p_rc = ra * ca;
      p_rr = ra * ra;
      p_cc = ca * ca;
   end

   // Datapath helpers for the square root and division steps.
   always_comb begin
      ssum   = root_ff + bit_ff;
      absdot = dot_ff[32] ? 33'(-dot_ff) : 33'(dot_ff);
      trial  = (step_ff == 5'd0) ? {1'b0, drem_ff} : {drem_ff, 1'b0};
      ge     = trial >= {2'b00, den_ff};
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      step_in   = step_ff;
      dot_in    = dot_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      den_in    = den_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      sim_in    = sim_ff;
      best_in   = best_ff;
      bsim_in   = bsim_ff;
      bpos_in   = bpos_ff;
      ovec_in   = ovec_ff;
      opos_in   = opos_ff;
      osim_in   = osim_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      case (state_ff)
         cnvs_pkg::ST_IDLE: begin
            if (q_valid) begin
               item_in  = q_data;
               step_in  = 5'd0;
               dot_in   = '0;
               na_in    = '0;
               nb_in    = '0;
               state_in = q_data.cmp ? cnvs_pkg::ST_PROD : cnvs_pkg::ST_UPDT;
            end
         end
         // Accumulate one component per cycle.
         cnvs_pkg::ST_PROD: begin
            dot_in  = dot_ff + 33'(p_rc);
            na_in   = na_ff + 32'(unsigned'(p_rr));
            nb_in   = nb_ff + 32'(unsigned'(p_cc));
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd2) begin
               state_in = cnvs_pkg::ST_NORM;
            end
         end
         // Zero length gives similarity zero; otherwise form the product of the squared lengths.
         cnvs_pkg::ST_NORM: begin
            step_in = 5'd0;
            if (na_ff == '0 || nb_ff == '0) begin
               sim_in   = '0;
               state_in = cnvs_pkg::ST_UPDT;
            end else begin
               srem_in  = 64'(na_ff) * 64'(nb_ff);
               root_in  = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = cnvs_pkg::ST_SQRT;
            end
         end
         // One root bit per cycle.
         cnvs_pkg::ST_SQRT: begin
            if (srem_ff >= ssum) begin
               srem_in = srem_ff - ssum;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               step_in  = 5'd0;
               den_in   = root_in[31:0];
               drem_in  = absdot;
               quo_in   = '0;
               state_in = cnvs_pkg::ST_DIV;
            end
         end
         // One quotient bit per cycle; the magnitude never exceeds one.
         cnvs_pkg::ST_DIV: begin
            drem_in = ge ? 33'(trial - {2'b00, den_ff}) : 33'(trial);
            quo_in  = {quo_ff[14:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) begin
               if (dot_ff[32]) begin
                  sim_in = 16'(-$signed({1'b0, quo_in}));
               end else begin
                  sim_in = quo_in[15] ? $signed(cnvs_pkg::SIM_MAX) : $signed(quo_in);
               end
               state_in = cnvs_pkg::ST_UPDT;
            end
         end
         // Strictly greater replaces, so the earliest candidate wins a tie.
         cnvs_pkg::ST_UPDT: begin
            if (item_ff.cmp && (item_ff.start || sim_ff > bsim_ff)) begin
               best_in = item_ff.cand;
               bsim_in = sim_ff;
               bpos_in = item_ff.pos;
            end
            state_in = item_ff.last ? cnvs_pkg::ST_EMIT : cnvs_pkg::ST_IDLE;
         end
         cnvs_pkg::ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               ovec_in   = best_ff;
               opos_in   = bpos_ff;
               osim_in   = bsim_ff;
               state_in  = cnvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cnvs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      step_ff <= step_in;
      dot_ff  <= dot_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      den_ff  <= den_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      sim_ff  <= sim_in;
      ovec_ff <= ovec_in;
      opos_ff <= opos_in;
      osim_ff <= osim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cnvs_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
         best_ff   <= '0;
         bsim_ff   <= '0;
         bpos_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         best_ff   <= best_in;
         bsim_ff   <= bsim_in;
         bpos_ff   <= bpos_in;
      end
   end

   // The divisor is never zero once division starts.
   `CNVS_ASSERT_IMP(a_den_nonzero, clock, reset, state_ff == cnvs_pkg::ST_DIV, den_ff != '0)
   // The quotient magnitude stays within one.
   `CNVS_ASSERT_IMP(a_quo_bound, clock, reset,
      state_ff == cnvs_pkg::ST_DIV && step_ff == 5'd15, quo_in <= 16'h8000)
   // A result leaving the emit state is presented in the next cycle.
   `CNVS_ASSERT_NXT(a_emit_shown, clock, reset,
      state_ff == cnvs_pkg::ST_EMIT && out_free, rsp_valid)

endmodule

`default_nettype wire

// File: test/tb_cosine_nearest_vector_select_core.sv
// Self-checking testbench for cosine_nearest_vector_select_core.
// Depends on cnvs_pkg and the core RTL. Predicts every winner with an
// internal model of the similarity arithmetic and checks each result beat.
`timescale 1ns / 100ps
`default_nettype none

module tb_cosine_nearest_vector_select_core;

   localparam int MAX_CAND   = cnvs_pkg::MAX_CANDIDATES_DEFAULT;
   localparam int CYCLE_LIMIT = 1500000;

   // Expected winner of one set.
   typedef struct {
      logic signed [15:0] north;
      logic signed [15:0] east;
      logic signed [15:0] down;
      logic [7:0]         index;
      logic signed [15:0] similarity;
   } winner_type;

   // Tracks the running best of the open set and holds the expected winners.
   class nearest_board;
      logic signed [15:0] held_ref [3];
      logic signed [15:0] best_vec [3];
      logic signed [15:0] best_sim;
      int                 best_pos;
      int                 taken;
      winner_type         winner_q[$];
      int                 errors;

      function new();
         for (int i = 0; i < 3; i++) begin
            held_ref[i] = '0;
            best_vec[i] = '0;
         end
         best_sim = '0;
         best_pos = 0;
         taken = 0;
         errors = 0;
      endfunction

      // Integer square root, floor, over 64 bits.
      function longint unsigned root64(longint unsigned n);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Cosine similarity in Q1.15 of the held reference and a candidate.
      function logic signed [15:0] cosine(logic signed [15:0] c [3]);
         longint          dot;
         longint unsigned na;
         longint unsigned nb;
         longint          den;
         longint          q;
         dot = 0;
         na = 0;
         nb = 0;
         for (int i = 0; i < 3; i++) begin
            dot += longint'(held_ref[i]) * longint'(c[i]);
            na  += longint'(held_ref[i]) * longint'(held_ref[i]);
            nb  += longint'(c[i]) * longint'(c[i]);
         end
         if (na == 0 || nb == 0) return '0;
         den = longint'(root64(na * nb));
         q = (dot * 32768) / den;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      // Notes one accepted input beat.
      function void note_candidate(logic signed [15:0] r [3], logic signed [15:0] c [3],
                                   bit first, bit last);
         logic signed [15:0] s;
         winner_type         w;
         if (first) begin
            held_ref = r;
            taken = 0;
         end
         if (taken < MAX_CAND) begin
            s = cosine(c);
            if (taken == 0 || s > best_sim) begin
               best_sim = s;
               best_pos = taken;
               best_vec = c;
            end
            taken++;
         end
         if (last) begin
            w.north = best_vec[0];
            w.east = best_vec[1];
            w.down = best_vec[2];
            w.index = best_pos[7:0];
            w.similarity = best_sim;
            winner_q = {winner_q, w};
            taken = 0;
         end
      endfunction

      function void field(string name, logic [15:0] e, logic [15:0] a);
         if (e !== a) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, e, a);
            errors++;
         end
      endfunction

      // Checks one result beat against the oldest expected winner.
      function void check_winner(winner_type a);
         winner_type e;
         if (winner_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h",
                     $time, a.north, a.east, a.down, a.index, a.similarity);
            errors++;
            return;
         end
         e = winner_q.pop_front();
         field("best_north", e.north, a.north);
         field("best_east", e.east, a.east);
         field("best_down", e.down, a.down);
         field("best_index", {8'h00, e.index}, {8'h00, a.index});
         field("best_similarity", e.similarity, a.similarity);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_ref_north;
   logic signed [15:0] req_ref_east;
   logic signed [15:0] req_ref_down;
   logic signed [15:0] req_cand_north;
   logic signed [15:0] req_cand_east;
   logic signed [15:0] req_cand_down;
   logic               req_first;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_best_north;
   logic signed [15:0] rsp_best_east;
   logic signed [15:0] rsp_best_down;
   logic [7:0]         rsp_best_index;
   logic signed [15:0] rsp_best_similarity;

   nearest_board board;
   bit           steady;
   int           cycles;
   int           rsp_wait;

   cosine_nearest_vector_select_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ref_north(req_ref_north), .req_ref_east(req_ref_east),
      .req_ref_down(req_ref_down), .req_cand_north(req_cand_north),
      .req_cand_east(req_cand_east), .req_cand_down(req_cand_down),
      .req_first(req_first), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_best_north(rsp_best_north), .rsp_best_east(rsp_best_east),
      .rsp_best_down(rsp_best_down), .rsp_best_index(rsp_best_index),
      .rsp_best_similarity(rsp_best_similarity)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_cosine_nearest_vector_select_core: errors");
         $finish;
      end
   end

   // Result side: check each accepted beat, then stall for a drawn number of cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            winner_type a;
            a.north = rsp_best_north;
            a.east = rsp_best_east;
            a.down = rsp_best_down;
            a.index = rsp_best_index;
            a.similarity = rsp_best_similarity;
            board.check_winner(a);
            rsp_wait = steady ? 0 : $urandom_range(0, 3);
            rsp_ready <= (rsp_wait == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            if (rsp_wait == 0) rsp_ready <= 1'b1;
         end
      end
   end

   // Drives one input beat after a drawn gap and waits for its acceptance.
   task automatic send_beat(logic signed [15:0] rn, logic signed [15:0] re,
                            logic signed [15:0] rd, logic signed [15:0] cn,
                            logic signed [15:0] ce, logic signed [15:0] cd,
                            bit first, bit last);
      int                 gap;
      logic signed [15:0] r [3];
      logic signed [15:0] c [3];
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ref_north <= rn;
      req_ref_east <= re;
      req_ref_down <= rd;
      req_cand_north <= cn;
      req_cand_east <= ce;
      req_cand_down <= cd;
      req_first <= first;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      r = '{rn, re, rd};
      c = '{cn, ce, cd};
      board.note_candidate(r, c, first, last);
   endtask

   // A random component: mostly full range, sometimes extremes, zero or small.
   function automatic logic signed [15:0] pick_comp();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3, 4: return $signed(16'($urandom_range(0, 1023)) - 16'sd512);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] rn, re, rd, cn, ce, cd;
      int                 len;
      int                 sent;
      int                 kind;
      bit                 zero_vec;
      board = new();
      steady = 1'b0;
      cycles = 0;
      rsp_wait = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ref_north = '0;
      req_ref_east = '0;
      req_ref_down = '0;
      req_cand_north = '0;
      req_cand_east = '0;
      req_cand_down = '0;
      req_first = 1'b0;
      req_last = 1'b0;
      rsp_ready = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vectors, extremes, ties, a single-beat set, a missing first.
      send_beat(16'sd256, 0, 0, 0, 0, 0, 1, 0);
      send_beat(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0);
      send_beat(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0);
      send_beat(0, 0, 0, 16'sd512, 0, 0, 0, 0);
      send_beat(0, 0, 0, 16'sd100, 0, 0, 0, 1);
      send_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 1);
      send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 1);
      send_beat(0, 0, 0, 16'sd300, 16'sd1, 16'sd7, 1, 0);
      send_beat(16'sh7FFF, 0, 0, 16'sd3, 16'sd2, 16'sd1, 0, 1);
      send_beat(16'sd1, 16'sd1, 16'sd1, 0, 0, 0, 0, 0);
      send_beat(0, 0, 0, -16'sd5, -16'sd5, -16'sd5, 0, 0);
      send_beat(0, 0, 0, 16'sd9, 16'sd9, 16'sd9, 0, 1);
      send_beat(16'sd1, -16'sd2, 16'sd3, -16'sd1, 16'sd2, -16'sd3, 1, 0);
      send_beat(0, 0, 0, 16'sh8000, 0, 0, 0, 0);
      send_beat(0, 0, 0, 0, 16'sh7FFF, 0, 0, 1);

      // Random sets: mostly short, ties and multiples of the reference, a few overlong.
      cn = '0;
      ce = '0;
      cd = '0;
      sent = 0;
      while (sent < 1500) begin
         if ($urandom_range(0, 7) == 0) steady = ~steady;
         rn = pick_comp();
         re = pick_comp();
         rd = pick_comp();
         if ($urandom_range(0, 299) == 0) len = $urandom_range(MAX_CAND + 1, MAX_CAND + 20);
         else len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 9);
            zero_vec = (kind == 0);
            if (kind == 1) begin
               // Repeat the previous candidate for a tie.
            end else if (kind == 2) begin
               cn = rn >>> 1;
               ce = re >>> 1;
               cd = rd >>> 1;
            end else if (kind == 3) begin
               cn = -rn;
               ce = -re;
               cd = -rd;
            end else begin
               cn = zero_vec ? 16'sd0 : pick_comp();
               ce = zero_vec ? 16'sd0 : pick_comp();
               cd = zero_vec ? 16'sd0 : pick_comp();
            end
            send_beat(rn, re, rd, cn, ce, cd,
                      (k == 0) && ($urandom_range(0, 15) != 0), k == len - 1);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the back end to settle.
      while (board.winner_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_cosine_nearest_vector_select_core: clean");
      end else begin
         $display("tb_cosine_nearest_vector_select_core: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
